/* design/wildcard_byte_pattern_scanner_assert.svh */
// assertion macros for the wildcard byte pattern scanner
// used by the top level; expects a clock named clk and a reset named rst
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WBPS_ASSERT_SAME(label, ant, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("wbps same-cycle check failed");
// next-cycle implication
`define WBPS_ASSERT_NEXT(label, ant, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("wbps next-cycle check failed");
`else
`define WBPS_ASSERT_SAME(label, ant, cons)
`define WBPS_ASSERT_NEXT(label, ant, cons)
`endif
`endif

/* design/wbps_pkg.sv */
// shared types and constants for the wildcard byte pattern scanner
// no dependencies
package wbps_pkg;

  localparam int MAX_PATTERN = 256;
  localparam int OFFSET_BITS = 32;
  localparam int PTR_W = $clog2(MAX_PATTERN);
  // index width wide enough for both the 8-bit field and the store depth
  localparam int IDX_W = (PTR_W > 8) ? PTR_W : 8;
  localparam int MATCH_OFFSET_W = 32;
  localparam logic [7:0] WILDCARD = 8'hff;
  localparam logic [7:0] LENGTH_RESET = 8'd1;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_SCAN    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] pattern_index;
    logic [7:0] pattern_value;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic                      valid;
    logic                      found;
    logic [MATCH_OFFSET_W-1:0] match_offset;
  } result_t;

  typedef struct packed {
    logic finished;
  } status_t;

endpackage

/* design/wbps_input_stage.sv */
// input register for the scanner item stream
// depends on wbps_pkg
module wbps_input_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [23:0]    s_tdata,   // pattern_index, pattern_value, data_byte
  input  logic [1:0]     s_tuser,   // command
  input  logic           s_tlast,   // last_byte
  input  logic           advance,
  output logic           item_valid,
  output wbps_pkg::item_t item
);

  // take a new transfer when empty or when the held item moves on
  assign s_tready = !item_valid || advance;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.command       <= wbps_pkg::cmd_t'(s_tuser);
      item.pattern_index <= s_tdata[7:0];
      item.pattern_value <= s_tdata[15:8];
      item.data_byte     <= s_tdata[23:16];
      item.last_byte     <= s_tlast;
    end
  end

endmodule

/* design/wbps_match_core.sv */
// pattern store, shift-and partial match bits and scan position
// depends on wbps_pkg
module wbps_match_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [7:0]          cfg_data,
  input  logic                advance,
  input  wbps_pkg::item_t     item,
  output wbps_pkg::result_t   result,
  output wbps_pkg::status_t   status
);

  logic [7:0]                       pattern_store [wbps_pkg::MAX_PATTERN];
  logic [wbps_pkg::MAX_PATTERN-1:0] partial_bits;
  logic [wbps_pkg::MAX_PATTERN-1:0] partial_bits_next;
  logic [wbps_pkg::MAX_PATTERN-1:0] lane_match;
  logic [wbps_pkg::OFFSET_BITS-1:0] byte_position;
  logic [wbps_pkg::OFFSET_BITS-1:0] start_offset;
  logic [7:0]                       pattern_length;
  logic                             finished;
  logic [wbps_pkg::IDX_W-1:0]       load_index;
  logic [wbps_pkg::IDX_W-1:0]       length_m1;
  logic [wbps_pkg::PTR_W-1:0]       hit_sel;
  logic                             load_ok;
  logic                             length_ok;
  logic                             scan_go;
  logic                             hit;

  // length register from the configuration channel
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= wbps_pkg::LENGTH_RESET;
    end else if (cfg_valid) begin
      pattern_length <= cfg_data;
    end
  end

  // pattern store write
  assign load_index = wbps_pkg::IDX_W'(item.pattern_index);
  assign load_ok    = int'(load_index) < wbps_pkg::MAX_PATTERN;

  always_ff @(posedge clk) begin
    if (advance && item.command == wbps_pkg::CMD_LOAD && load_ok) begin
      pattern_store[load_index[wbps_pkg::PTR_W-1:0]] <= item.pattern_value;
    end
  end

  // per-lane compare against the current data byte
  always_comb begin
    for (int j = 0; j < wbps_pkg::MAX_PATTERN; j++) begin
      lane_match[j] = (pattern_store[j] == wbps_pkg::WILDCARD) ||
                      (pattern_store[j] == item.data_byte);
    end
  end

  // shift-and update and full-match pick
  assign partial_bits_next = {partial_bits[wbps_pkg::MAX_PATTERN-2:0], 1'b1} & lane_match;
  assign length_ok  = (pattern_length != 8'd0) &&
                      (int'(pattern_length) < wbps_pkg::MAX_PATTERN);
  assign length_m1  = wbps_pkg::IDX_W'(pattern_length) - wbps_pkg::IDX_W'(1);
  assign hit_sel    = length_m1[wbps_pkg::PTR_W-1:0];
  assign scan_go    = (item.command == wbps_pkg::CMD_SCAN) && !finished;
  assign hit        = length_ok && partial_bits_next[hit_sel];
  assign start_offset = byte_position - wbps_pkg::OFFSET_BITS'(length_m1);

  // result for the held item
  always_comb begin
    result.valid        = scan_go && (hit || item.last_byte);
    result.found        = hit;
    result.match_offset = hit ? wbps_pkg::MATCH_OFFSET_W'(start_offset)
                              : '0;
  end

  assign status.finished = finished;

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_bits  <= '0;
      byte_position <= '0;
      finished      <= 1'b0;
    end else if (advance) begin
      unique case (item.command)
        wbps_pkg::CMD_RESTART: begin
          partial_bits  <= '0;
          byte_position <= '0;
          finished      <= 1'b0;
        end
        wbps_pkg::CMD_SCAN: begin
          if (!finished) begin
            partial_bits  <= partial_bits_next;
            byte_position <= byte_position + wbps_pkg::OFFSET_BITS'(1);
            finished      <= hit || item.last_byte;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* design/wbps_result_stage.sv */
// output register for scan results
// depends on wbps_pkg
module wbps_result_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  wbps_pkg::result_t result,
  output logic              slot_free,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,   // match_offset
  output logic [0:0]        m_tuser    // found
);

  // a new result may enter when empty or when the current one is taken
  assign slot_free = !m_tvalid || m_tready;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (slot_free) begin
      m_tvalid <= advance && result.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (slot_free && advance && result.valid) begin
      m_tdata    <= result.match_offset;
      m_tuser[0] <= result.found;
    end
  end

endmodule

/* design/wildcard_byte_pattern_scanner.sv */
// Wildcard byte pattern scanner: load pattern bytes by index (0xff is a wildcard),
// then stream region bytes; one result is given on the first full match (with its
// start offset) or a not-found result on the region's last byte, after which scan
// bytes are ignored until a restart. One item is taken every cycle; a result
// appears on the master side after its item has passed the input register and
// the output register. The rate is set by the shift-and update, which compares
// every pattern lane against the byte in parallel, and by the output register:
// while a result is held and not taken, the item behind it waits.
// depends on wbps_pkg, wbps_input_stage, wbps_match_core, wbps_result_stage
`include "wildcard_byte_pattern_scanner_assert.svh"

module wildcard_byte_pattern_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,   // pattern_length
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // pattern_index, pattern_value, data_byte
  input  logic [1:0]  s_tuser,    // command
  input  logic        s_tlast,    // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // match_offset
  output logic [0:0]  m_tuser     // found
);

  wbps_pkg::item_t   item;
  wbps_pkg::result_t result;
  wbps_pkg::status_t status;
  logic              item_valid;
  logic              slot_free;
  logic              advance;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  // the held item moves on when the result slot can take it
  assign advance = item_valid && slot_free;

  wbps_input_stage u_input (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  wbps_match_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .item      (item),
    .result    (result),
    .status    (status)
  );

  wbps_result_stage u_result (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .result    (result),
    .slot_free (slot_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // checks
  `WBPS_ASSERT_NEXT(a_result_ends_scan, advance && result.valid, status.finished)
  `WBPS_ASSERT_SAME(a_no_result_after_end, advance && status.finished, !result.valid)
  `WBPS_ASSERT_SAME(a_not_found_offset_zero, m_tvalid && !m_tuser[0], m_tdata == 32'd0)
  `WBPS_ASSERT_SAME(a_stall_only_when_held, !s_tready, item_valid && !slot_free)

endmodule

/* verif/tb_wildcard_byte_pattern_scanner.sv */
// self-checking testbench for the wildcard byte pattern scanner
// drives the config and stream ports and predicts results with a shift-and model
// depends on wbps_pkg and the wildcard_byte_pattern_scanner top level
module tb_wildcard_byte_pattern_scanner;

  localparam logic [1:0] CMD_NOP = 2'd3;  // unused command code, must do nothing
  localparam int SETTLE_CYCLES = 6;       // result latency plus margin
  localparam int HOLD_CYCLES = 300;       // long receiver hold-off
  localparam int ITEM_TARGET = 1300;      // store fill and directed part included

  typedef struct {
    logic        found;
    logic [31:0] offset;
  } scan_result_t;

  // predicts scan results and checks them against the output stream
  class match_scoreboard;
    logic [7:0]                       sig_store [wbps_pkg::MAX_PATTERN];
    logic [wbps_pkg::MAX_PATTERN-1:0] prefix_bits;
    logic [31:0]                      next_offset;
    bit                               done;
    int                               sig_len;
    scan_result_t                     expected_hits [$];
    int                               errors;

    function new();
      int j;
      for (j = 0; j < wbps_pkg::MAX_PATTERN; j++) sig_store[j] = 8'h00;
      prefix_bits = '0;
      next_offset = '0;
      done = 1'b0;
      sig_len = wbps_pkg::LENGTH_RESET;
      errors = 0;
    endfunction

    function void set_length(logic [7:0] len);
      sig_len = len;
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction

    // update the scan state for one accepted item, queue any result it causes
    function void note_item(logic [1:0] cmd, logic [7:0] idx, logic [7:0] val,
                            logic [7:0] data, logic last);
      logic [wbps_pkg::MAX_PATTERN-1:0] lane_hit;
      logic [31:0]                      pos;
      scan_result_t                     r;
      int                               j;
      if (cmd == wbps_pkg::CMD_LOAD) begin
        sig_store[idx] = val;
        return;
      end
      if (cmd == wbps_pkg::CMD_RESTART) begin
        prefix_bits = '0;
        next_offset = '0;
        done = 1'b0;
        return;
      end
      if (cmd != wbps_pkg::CMD_SCAN || done) return;
      for (j = 0; j < wbps_pkg::MAX_PATTERN; j++)
        lane_hit[j] = (sig_store[j] == wbps_pkg::WILDCARD) || (sig_store[j] == data);
      prefix_bits = {prefix_bits[wbps_pkg::MAX_PATTERN-2:0], 1'b1} & lane_hit;
      pos = next_offset;
      next_offset = pos + 32'd1;
      // a length of zero never matches; the last byte then ends the region
      if (sig_len >= 1 && sig_len < wbps_pkg::MAX_PATTERN && prefix_bits[sig_len-1]) begin
        done = 1'b1;
        r.found = 1'b1;
        r.offset = pos - 32'(sig_len - 1);
        expected_hits.push_back(r);
      end else if (last) begin
        done = 1'b1;
        r.found = 1'b0;
        r.offset = '0;
        expected_hits.push_back(r);
      end
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_result(logic found, logic [31:0] offset);
      scan_result_t want;
      if (expected_hits.size() == 0) begin
        report($sformatf("result with none expected: found=%0b offset=%0d", found, offset));
        return;
      end
      want = expected_hits.pop_front();
      if (found !== want.found)
        report($sformatf("found=%0b, expected %0b", found, want.found));
      if (offset !== want.offset)
        report($sformatf("match_offset=%0d, expected %0d", offset, want.offset));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = 24'd0;
  logic [1:0]  s_tuser = 2'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;

  match_scoreboard sb = new();
  logic [7:0] sig_copy [wbps_pkg::MAX_PATTERN];  // pattern as loaded, used to plant matches

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int items_sent = 0;

  wildcard_byte_pattern_scanner u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // check every result transfer
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser[0], m_tdata);
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(255));
  endfunction

  // wildcard about one time in four
  function automatic logic [7:0] pick_sig_byte();
    return ($urandom_range(3) == 0) ? wbps_pkg::WILDCARD : rnd8();
  endfunction

  // offer one item with random idle gaps, return once it is transferred
  task automatic send_item(logic [1:0] cmd, logic [7:0] idx, logic [7:0] val,
                           logic [7:0] data, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {data, val, idx};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(cmd, idx, val, data, last);
    items_sent++;
  endtask

  task automatic load_byte(logic [7:0] idx, logic [7:0] val);
    sig_copy[idx] = val;
    send_item(wbps_pkg::CMD_LOAD, idx, val, rnd8(), 1'($urandom_range(1)));
  endtask

  task automatic scan_byte(logic [7:0] data, logic last);
    send_item(wbps_pkg::CMD_SCAN, rnd8(), rnd8(), data, last);
  endtask

  task automatic restart_scan();
    send_item(wbps_pkg::CMD_RESTART, rnd8(), rnd8(), rnd8(), 1'($urandom_range(1)));
  endtask

  // stop sending and wait until every expected result has come
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(logic [7:0] len);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_length(len);
    cfg_valid <= 1'b0;
  endtask

  // unused command, stray load or restart in the middle of a region
  task automatic send_noise();
    case ($urandom_range(2))
      0: send_item(CMD_NOP, rnd8(), rnd8(), rnd8(), 1'($urandom_range(1)));
      1: load_byte(rnd8(), pick_sig_byte());
      default: restart_scan();
    endcase
  endtask

  // restart, then one region with the pattern planted at a random spot
  task automatic send_region(int nbytes, int plant_len, bit noisy);
    int at;
    int i;
    logic [7:0] b;
    restart_scan();
    at = (plant_len > 0 && nbytes >= plant_len) ? $urandom_range(nbytes - plant_len) : -1;
    for (i = 0; i < nbytes; i++) begin
      if (noisy && $urandom_range(24) == 0) send_noise();
      b = rnd8();
      if (at >= 0 && i >= at && i < at + plant_len && sig_copy[i-at] != wbps_pkg::WILDCARD)
        b = sig_copy[i-at];
      scan_byte(b, i == nbytes - 1);
    end
    // bytes after the region has finished are ignored
    if (noisy && $urandom_range(3) == 0) scan_byte(rnd8(), 1'($urandom_range(1)));
  endtask

  initial begin
    int phase;
    int len;
    int nreg;
    int r;
    int j;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // fill the whole store so no entry is ever read unwritten
    for (j = 0; j < wbps_pkg::MAX_PATTERN; j++) load_byte(8'(j), rnd8());

    // directed part at the reset length of one
    load_byte(8'd0, 8'hab);
    load_byte(8'd255, wbps_pkg::WILDCARD);
    restart_scan();
    scan_byte(8'h00, 1'b0);
    scan_byte(8'hab, 1'b0);   // hit at offset one
    scan_byte(8'hab, 1'b1);   // ignored, scan already finished
    restart_scan();
    scan_byte(8'h12, 1'b1);   // not found on last byte
    send_item(CMD_NOP, 8'hff, 8'hff, 8'hff, 1'b1);
    load_byte(8'd0, wbps_pkg::WILDCARD);
    restart_scan();
    scan_byte(8'h55, 1'b0);   // wildcard hit on the first byte

    // match completing on the last byte
    write_length(8'd2);
    load_byte(8'd1, 8'h00);
    restart_scan();
    scan_byte(8'h01, 1'b0);
    scan_byte(8'h00, 1'b1);

    // zero length never matches
    write_length(8'd0);
    restart_scan();
    scan_byte(8'hff, 1'b0);
    scan_byte(8'h00, 1'b1);

    // random phases, each with its own length and idling mode; every mode runs at least once
    phase = 0;
    while (phase < 4 || items_sent < ITEM_TARGET) begin
      if (phase == 1) len = 255;
      else if (phase == 3) len = 0;
      else if (phase == 5) len = 1;
      else if ($urandom_range(9) == 0) len = $urandom_range(9, 64);
      else len = $urandom_range(1, 8);
      write_length(8'(len));
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 67;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 67;
        end
        default: begin
          send_idle_pct = 22;
          stall_pct = 22;
        end
      endcase
      for (j = 0; j < len; j++) load_byte(8'(j), pick_sig_byte());
      // receiver holds off while regions keep coming, so the block backs up
      if (phase == 2) hold_requests++;
      nreg = (len == 255) ? 1 : $urandom_range(4, 10);
      for (r = 0; r < nreg; r++) begin
        if (len == 0)
          send_region($urandom_range(1, 20), 0, 1'b1);
        else if (len == 255)
          send_region($urandom_range(255, 300), ($urandom_range(9) < 7) ? len : 0, 1'b0);
        else
          send_region($urandom_range(len, len + 30), ($urandom_range(9) < 7) ? len : 0,
                      1'b1);
      end
      phase++;
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
